@@ hw/rtl/dvmp_pkg.sv @@
// types and constants shared by the directional vibration motor pwm block
// depends on nothing; used by dvmp_div and directional_vibration_motor_pwm
package dvmp_pkg;

  // field widths fixed by the stream format
  localparam int VEC_W      = 9;
  localparam int TIME_W     = 32;
  localparam int VIS_MOTORS = 6;
  localparam int S_DATA_W   = 56;
  localparam int M_DATA_W   = 16;

  // configuration register indexes and reset values
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_FLOOR = 2'd2;
  localparam logic [15:0] PULSE_LEN_RST   = 16'd100;
  localparam logic [7:0]  PWM_PERIOD_RST  = 8'd20;
  localparam logic [15:0] POWER_FLOOR_RST = 16'd32768;

  localparam logic [0:0] OP_SET  = 1'b0;
  localparam logic [0:0] OP_TICK = 1'b1;

  // bit-serial divider sizes: divisor is either len2 (18 bits) or the period
  localparam int DIV_REM_W  = 18;
  localparam int DIV_SR_W   = 32;
  localparam int DIV_CNT_W  = 6;
  localparam int QUOT_W     = 16;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_RATIO = 6'd16;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_TIME  = 6'd32;

  typedef struct packed {
    logic                  start;
    logic [DIV_REM_W-1:0]  rem_init;
    logic [DIV_SR_W-1:0]   dividend;
    logic [DIV_CNT_W-1:0]  nbits;
    logic [DIV_REM_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [QUOT_W-1:0]     quot;
    logic [DIV_REM_W-1:0]  rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN,
    ST_PROJ,
    ST_SQR,
    ST_DSTART,
    ST_TCHK,
    ST_DWAIT,
    ST_OUT
  } state_t;

endpackage

@@ hw/rtl/directional_vibration_motor_pwm.sv @@
// top level: six-way directional vibration motor driver with software pwm
// depends on dvmp_pkg and dvmp_div
//
//   channel  dir  signals                         contents
//   s_*      in   s_tvalid s_tready s_tdata s_tuser  set or tick item
//   m_*      out  m_tvalid m_tready m_tdata       enables, active mask
//   cfg_*    in   cfg_wen cfg_index cfg_wdata     pulse_len, pwm_period, power_floor
//
// one item at a time, motors handled in turn; the bit-serial divider sets the pace.
// set: each motor is projected and squared; a motor with a positive projection then runs the divider.
// (16 divider steps per such motor for the power ratio)
// tick: each running motor that has not timed out runs the divider for a 32-step phase modulo.
// a finished result sits in the output register while the next item is taken;
// the block waits before writing a new result only while that register is still full.
// rst is synchronous; it clears motor state and loads the register defaults.
module directional_vibration_motor_pwm import dvmp_pkg::*; #(
  parameter int MOTOR_COUNT     = 6,
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,   // vec_y[8:0], vec_z[17:9], now[49:18], zero pad
  input  logic                  s_tuser,   // op: 0 set, 1 tick
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_DATA_W-1:0]   m_tdata,   // enables[5:0], active_mask[11:6], zero pad
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int F      = COORD_FRAC_BITS;
  localparam int IW     = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int DirW   = F + 2;
  localparam int PW     = DirW + 11;
  localparam int PMagW  = F + 9;
  localparam int P2W    = 2 * PMagW;
  localparam int Shift  = 2 * F - 16;
  localparam int VisW   = (MOTOR_COUNT < VIS_MOTORS) ? MOTOR_COUNT : VIS_MOTORS;
  localparam int Dir0p8  = ((8 << F) + 5) / 10;
  localparam int Dir0p5  = 1 << (F - 1);
  localparam int Dir0p94 = ((94 << F) + 50) / 100;
  localparam logic signed [DirW-1:0] DirA  = DirW'(Dir0p8);
  localparam logic signed [DirW-1:0] DirAN = DirW'(-Dir0p8);
  localparam logic signed [DirW-1:0] DirH  = DirW'(Dir0p5);
  localparam logic signed [DirW-1:0] DirHN = DirW'(-Dir0p5);
  localparam logic signed [DirW-1:0] DirB  = DirW'(Dir0p94);
  localparam logic signed [DirW-1:0] DirBN = DirW'(-Dir0p94);

  // configuration
  logic [15:0] pulse_len;
  logic [7:0]  pwm_period;
  logic [15:0] power_floor;
  logic [7:0]  eff_period;

  // item registers
  logic                    op;
  logic signed [9:0]       y_reg;
  logic signed [9:0]       z_reg;
  logic [TIME_W-1:0]       now_reg;
  logic [17:0]             len2;
  logic signed [PW-1:0]    p_reg;
  logic [P2W-1:0]          p2_reg;
  logic                    sticky;

  // per-motor state
  logic [TIME_W-1:0] off_time    [MOTOR_COUNT];
  logic [TIME_W-1:0] pulse_start [MOTOR_COUNT];
  logic [7:0]        duty_level  [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] motor_on;
  logic [MOTOR_COUNT-1:0] enable_bits;

  logic [IW-1:0] idx;
  logic [2:0]    k;
  logic          last_motor;

  state_t state, state_next, motor_done_state;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [DirW-1:0] dir_y, dir_z;
  logic signed [PW-1:0]   p_next;
  logic [17:0]            len2_next;
  logic                   p_pos;
  logic [P2W-1:0]         p2_shifted;
  logic [TIME_W-1:0]      phase_diff;
  logic                   timed_out;
  logic                   ratio_ok;
  logic [23:0]            duty_prod;

  logic in_acc, load_len, load_p, load_p2, load_sticky, step_motor, load_out;
  logic motor_clr, motor_set, en_wr, en_val;

  assign in_acc     = s_tvalid && s_tready;
  assign eff_period = (pwm_period == 8'd0) ? 8'd1 : pwm_period;
  assign last_motor = idx == IW'(MOTOR_COUNT - 1);

  // direction table, motor i uses entry i mod 6
  always_comb begin
    unique case (k)
      3'd0:    begin dir_y = DirA;  dir_z = DirH;  end
      3'd1:    begin dir_y = DirAN; dir_z = DirH;  end
      3'd2:    begin dir_y = '0;    dir_z = DirB;  end
      3'd3:    begin dir_y = '0;    dir_z = DirBN; end
      3'd4:    begin dir_y = DirAN; dir_z = DirHN; end
      3'd5:    begin dir_y = DirA;  dir_z = DirHN; end
      default: begin dir_y = '0;    dir_z = '0;    end
    endcase
  end

  always_comb begin
    len2_next  = 18'(y_reg * y_reg) + 18'(z_reg * z_reg);
    p_next     = PW'(y_reg * dir_y) + PW'(z_reg * dir_z);
    p_pos      = !p_reg[PW-1] && (p_reg != '0);
    p2_shifted = p2_reg >> Shift;
    phase_diff = now_reg - pulse_start[idx];
    timed_out  = now_reg >= off_time[idx];
    // p2 > power_floor * den, from the quotient, remainder and dropped low bits
    ratio_ok   = (div_rsp.quot > power_floor) ||
                 ((div_rsp.quot == power_floor) && ((div_rsp.rem != '0) || sticky));
    duty_prod  = 24'(div_rsp.quot) * 24'(eff_period);
  end

  // next state
  always_comb begin
    motor_done_state = last_motor ? ST_OUT : ((op == OP_TICK) ? ST_TCHK : ST_PROJ);
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = (s_tuser == OP_TICK) ? ST_TCHK : ST_LEN;
      ST_LEN:    state_next = ST_PROJ;
      ST_PROJ:   state_next = ST_SQR;
      ST_SQR:    state_next = p_pos ? ST_DSTART : motor_done_state;
      ST_DSTART: state_next = ST_DWAIT;
      ST_TCHK:   state_next = (timed_out || !motor_on[idx]) ? motor_done_state : ST_DWAIT;
      ST_DWAIT:  if (div_rsp.done) state_next = motor_done_state;
      ST_OUT:    if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready    = 1'b0;
    load_len    = 1'b0;
    load_p      = 1'b0;
    load_p2     = 1'b0;
    load_sticky = 1'b0;
    step_motor  = 1'b0;
    load_out    = 1'b0;
    motor_clr   = 1'b0;
    motor_set   = 1'b0;
    en_wr       = 1'b0;
    en_val      = 1'b0;
    div_req.start    = 1'b0;
    div_req.rem_init = '0;
    div_req.dividend = phase_diff;
    div_req.nbits    = DIV_STEPS_TIME;
    div_req.divisor  = DIV_REM_W'(eff_period);
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_LEN:  load_len = 1'b1;
      ST_PROJ: load_p   = 1'b1;
      ST_SQR: begin
        if (p_pos) begin
          load_p2 = 1'b1;
        end else begin
          motor_clr  = 1'b1;
          step_motor = 1'b1;
        end
      end
      ST_DSTART: begin
        load_sticky      = 1'b1;
        div_req.start    = 1'b1;
        div_req.rem_init = p2_shifted[33:16];
        div_req.dividend = {p2_shifted[15:0], 16'd0};
        div_req.nbits    = DIV_STEPS_RATIO;
        div_req.divisor  = len2;
      end
      ST_TCHK: begin
        if (timed_out) begin
          motor_clr  = 1'b1;
          step_motor = 1'b1;
        end else if (!motor_on[idx]) begin
          step_motor = 1'b1;
        end else begin
          div_req.start = 1'b1;
        end
      end
      ST_DWAIT: begin
        if (div_rsp.done) begin
          step_motor = 1'b1;
          if (op == OP_TICK) begin
            en_wr  = 1'b1;
            en_val = div_rsp.rem < DIV_REM_W'(duty_level[idx]);
          end else if (ratio_ok) begin
            motor_set = 1'b1;
          end else begin
            motor_clr = 1'b1;
          end
        end
      end
      ST_OUT:  load_out = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pulse_len   <= PULSE_LEN_RST;
      pwm_period  <= PWM_PERIOD_RST;
      power_floor <= POWER_FLOOR_RST;
      motor_on    <= '0;
      enable_bits <= '0;
      idx         <= '0;
      k           <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        unique case (cfg_index)
          CFG_PULSE_LEN:   pulse_len   <= cfg_wdata;
          CFG_PWM_PERIOD:  pwm_period  <= cfg_wdata[7:0];
          CFG_POWER_FLOOR: power_floor <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        idx <= '0;
        k   <= '0;
      end else if (step_motor) begin
        idx <= idx + IW'(1);
        k   <= (k == 3'd5) ? 3'd0 : k + 3'd1;
      end
      if (motor_clr) begin
        motor_on[idx]    <= 1'b0;
        enable_bits[idx] <= 1'b0;
      end
      if (motor_set) motor_on[idx] <= 1'b1;
      if (en_wr) enable_bits[idx] <= en_val;
      if (load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op      <= s_tuser;
      y_reg   <= $signed({s_tdata[8], s_tdata[8:0]}) + 10'sd1;
      z_reg   <= $signed({s_tdata[17], s_tdata[17:9]}) + 10'sd1;
      now_reg <= s_tdata[49:18];
    end
    if (load_len) len2 <= len2_next;
    if (load_p) p_reg <= p_next;
    if (load_p2) p2_reg <= P2W'(p_reg[PMagW-1:0]) * P2W'(p_reg[PMagW-1:0]);
    if (load_sticky) sticky <= p2_reg != (p2_shifted << Shift);
    if (motor_set) begin
      duty_level[idx]  <= duty_prod[23:16];
      off_time[idx]    <= now_reg + TIME_W'(pulse_len);
      pulse_start[idx] <= now_reg;
    end
    if (load_out) begin
      m_tdata <= {4'd0, VIS_MOTORS'(motor_on[VisW-1:0]), VIS_MOTORS'(enable_bits[VisW-1:0])};
    end
  end

  dvmp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

@@ hw/rtl/dvmp_div.sv @@
// restoring divider, one quotient bit per cycle, shared by ratio and pwm phase
// depends on dvmp_pkg
module dvmp_div import dvmp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_REM_W-1:0] rem;
  logic [DIV_SR_W-1:0]  sreg;
  logic [DIV_REM_W-1:0] dvs;

  logic [DIV_REM_W:0]   trial;
  logic                 ge;
  logic [DIV_REM_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, sreg[DIV_SR_W-1]};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? DIV_REM_W'(trial - {1'b0, dvs}) : trial[DIV_REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.nbits;
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits enter at the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.rem_init;
      sreg <= req.dividend;
      dvs  <= req.divisor;
    end else if (busy) begin
      rem  <= rem_next;
      sreg <= {sreg[DIV_SR_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = sreg[QUOT_W-1:0];
  assign rsp.rem  = rem;

endmodule
